// ----- design/dce_pkg.sv -----
package dce_pkg;

   // Register indexes on the configuration port.
   localparam logic CSR_SYSCLK_HZ     = 1'b0;
   localparam logic CSR_MAX_OUTPUT_HZ = 1'b1;

   // Command kinds.
   localparam logic [1:0] KIND_TONE  = 2'd0;
   localparam logic [1:0] KIND_FREQ  = 2'd1;
   localparam logic [1:0] KIND_PHASE = 2'd2;
   localparam logic [1:0] KIND_AMP   = 2'd3;

   // Synthesizer register addresses.
   localparam logic [7:0] ADDR_SELECT = 8'h00;
   localparam logic [7:0] ADDR_FREQ   = 8'h04;
   localparam logic [7:0] ADDR_PHASE  = 8'h05;
   localparam logic [7:0] ADDR_AMP    = 8'h06;
   localparam logic [7:0] SELECT_BASE = 8'h10;
   localparam logic [7:0] AMP_ENABLE  = 8'h10;

   // Reset values of the configuration registers.
   localparam logic [31:0] SYSCLK_RESET  = 32'd500000000;
   localparam logic [31:0] MAX_OUT_RESET = 32'd200000000;

   // Reciprocals for the phase word: floor(x / 360) for x below 2^16 and
   // floor(y / 45) for y below 2^20, both exact over those ranges.
   localparam logic [16:0] RECIP_360   = 17'd93207;   // ceil(2^25 / 360)
   localparam int          SHIFT_360   = 25;
   localparam logic [20:0] RECIP_45    = 21'd1491309; // ceil(2^26 / 45)
   localparam int          SHIFT_45    = 26;
   localparam logic [8:0]  DEG_CIRCLE  = 9'd360;

   // Positions in the full single-tone byte sequence. Shorter commands run
   // a slice of it: phase, amplitude and frequency each start at their own
   // channel-select frame.
   localparam logic [4:0] STEP_TONE      = 5'd0;
   localparam logic [4:0] STEP_PHASE     = 5'd2;
   localparam logic [4:0] STEP_PHASE_END = 5'd6;
   localparam logic [4:0] STEP_AMP       = 5'd7;
   localparam logic [4:0] STEP_AMP_END   = 5'd12;
   localparam logic [4:0] STEP_FREQ      = 5'd13;
   localparam logic [4:0] STEP_FREQ_END  = 5'd19;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  channel;
      logic [31:0] frequency_hz;
      logic [15:0] phase_deg;
      logic [15:0] amplitude;
   } req_type;

   typedef struct packed {
      logic [7:0] spi_byte;
      logic       has_byte;
      logic       frame_end;
      logic       io_update;
      logic       ok;
      logic       last;
   } rsp_type;

   // One classified command handed from the front part to the back part.
   typedef struct packed {
      logic        bad;
      logic [1:0]  kind;
      logic [1:0]  channel;
      logic [31:0] fword;
      logic [13:0] pword;
      logic [9:0]  amp;
   } cmd_type;

   function automatic logic [4:0] first_step(input logic [1:0] kind);
      logic [4:0] s;
      unique case (kind)
         KIND_TONE:  s = STEP_TONE;
         KIND_FREQ:  s = STEP_FREQ;
         KIND_PHASE: s = STEP_PHASE;
         default:    s = STEP_AMP;
      endcase
      return s;
   endfunction

   function automatic logic [4:0] final_step(input logic [1:0] kind);
      logic [4:0] s;
      unique case (kind)
         KIND_PHASE: s = STEP_PHASE_END;
         KIND_AMP:   s = STEP_AMP_END;
         default:    s = STEP_FREQ_END;
      endcase
      return s;
   endfunction

   // Byte at one position of the sequence.
   function automatic logic [7:0] seq_byte(input logic [4:0] step, input cmd_type c);
      logic [7:0] b;
      logic [7:0] sel;
      sel = 8'(SELECT_BASE << c.channel);
      unique case (step)
         5'd0, 5'd2, 5'd7, 5'd13: b = ADDR_SELECT;
         5'd1, 5'd3, 5'd8, 5'd14: b = sel;
         5'd4:  b = ADDR_PHASE;
         5'd5:  b = {2'd0, c.pword[13:8]};
         5'd6:  b = c.pword[7:0];
         5'd9:  b = ADDR_AMP;
         5'd10: b = 8'h00;
         5'd11: b = AMP_ENABLE | {6'd0, c.amp[9:8]};
         5'd12: b = c.amp[7:0];
         5'd15: b = ADDR_FREQ;
         5'd16: b = c.fword[31:24];
         5'd17: b = c.fword[23:16];
         5'd18: b = c.fword[15:8];
         5'd19: b = c.fword[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // Last byte of a frame.
   function automatic logic seq_frame_end(input logic [4:0] step);
      logic e;
      unique case (step)
         5'd1, 5'd3, 5'd6, 5'd8, 5'd12, 5'd14, 5'd19: e = 1'b1;
         default: e = 1'b0;
      endcase
      return e;
   endfunction

endpackage

// ----- design/dce_front.sv -----
module dce_front #(
   parameter int CHANNELS = 4,
   parameter int AMP_MAX  = 1023
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  dce_pkg::req_type req_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [31:0]      csr_wdata,
   output logic             q_push,
   input  logic             q_full,
   output dce_pkg::cmd_type q_data
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_PH1, ST_PH2, ST_PH3, ST_DIV, ST_PUSH
   } state_type;

   state_type   state_ff;
   logic [31:0] sysclk_ff;
   logic [31:0] max_out_ff;
   logic        bad_ff;
   logic [1:0]  kind_ff;
   logic [2:0]  channel_ff;
   logic [15:0] deg_ff;
   logic [9:0]  amp_ff;
   logic [32:0] prod1_ff;
   logic [8:0]  r_ff;
   logic [40:0] prod2_ff;
   logic [31:0] rem_ff;
   logic [31:0] quo_ff;
   logic [4:0]  cnt_ff;

   logic        accept;
   logic        ch_bad;
   logic        f_bad;
   logic [9:0]  amp_in;
   logic [7:0]  q360;
   logic [16:0] diff;
   logic [32:0] shifted;
   logic        ge;

   assign req_full = (state_ff != ST_IDLE);
   assign accept   = req_push && (state_ff == ST_IDLE);

   // Classification of the incoming item.
   assign ch_bad = ({29'd0, req_data.channel} >= 32'(CHANNELS));
   assign f_bad  = ((req_data.kind == dce_pkg::KIND_TONE) ||
                    (req_data.kind == dce_pkg::KIND_FREQ)) &&
                   ((req_data.frequency_hz > max_out_ff) ||
                    (req_data.frequency_hz >= (sysclk_ff >> 1)));
   assign amp_in = ({16'd0, req_data.amplitude} > 32'(AMP_MAX)) ? 10'(AMP_MAX)
                                                               : req_data.amplitude[9:0];

   // Phase reduction modulo a full circle.
   assign q360 = prod1_ff[32:25];
   assign diff = {1'b0, deg_ff} - (17'(q360) * 17'(dce_pkg::DEG_CIRCLE));

   // One restoring step of (f << 32) / sysclk; the remainder stays below sysclk.
   assign shifted = {rem_ff, 1'b0};
   assign ge      = (shifted >= {1'b0, sysclk_ff});

   assign q_push         = (state_ff == ST_PUSH) && !q_full;
   assign q_data.bad     = bad_ff;
   assign q_data.kind    = kind_ff;
   assign q_data.channel = channel_ff[1:0];
   assign q_data.fword   = quo_ff;
   assign q_data.pword   = prod2_ff[39:26];
   assign q_data.amp     = amp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         sysclk_ff  <= dce_pkg::SYSCLK_RESET;
         max_out_ff <= dce_pkg::MAX_OUT_RESET;
      end else begin
         // Configuration writes; a zero clock is ignored.
         if (csr_we) begin
            unique case (csr_index)
               dce_pkg::CSR_SYSCLK_HZ: begin
                  if (csr_wdata != 32'd0) sysclk_ff <= csr_wdata;
               end
               default: max_out_ff <= csr_wdata;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: if (accept) state_ff <= ST_PH1;
            ST_PH1:  state_ff <= ST_PH2;
            ST_PH2:  state_ff <= ST_PH3;
            ST_PH3: begin
               if (!bad_ff && ((kind_ff == dce_pkg::KIND_TONE) ||
                               (kind_ff == dce_pkg::KIND_FREQ))) state_ff <= ST_DIV;
               else state_ff <= ST_PUSH;
            end
            ST_DIV:  if (cnt_ff == 5'd31) state_ff <= ST_PUSH;
            ST_PUSH: if (!q_full) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end

      // Datapath registers.
      if (accept) begin
         bad_ff     <= ch_bad || f_bad;
         kind_ff    <= req_data.kind;
         channel_ff <= req_data.channel;
         deg_ff     <= req_data.phase_deg;
         amp_ff     <= amp_in;
         rem_ff     <= req_data.frequency_hz;
         quo_ff     <= 32'd0;
         cnt_ff     <= 5'd0;
      end
      if (state_ff == ST_PH1) prod1_ff <= 33'(deg_ff) * 33'(dce_pkg::RECIP_360);
      if (state_ff == ST_PH2) r_ff <= diff[8:0];
      if (state_ff == ST_PH3) prod2_ff <= 41'({r_ff, 11'd0}) * 41'(dce_pkg::RECIP_45);
      if (state_ff == ST_DIV) begin
         rem_ff <= ge ? 32'(shifted - {1'b0, sysclk_ff}) : shifted[31:0];
         quo_ff <= {quo_ff[30:0], ge};
         cnt_ff <= cnt_ff + 5'd1;
      end
   end

endmodule

// ----- design/dce_queue.sv -----
module dce_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  dce_pkg::cmd_type wdata,
   input  logic             pop,
   output logic             empty,
   output dce_pkg::cmd_type rdata
);

   dce_pkg::cmd_type entry_ff [2];
   logic       wptr_ff;
   logic       rptr_ff;
   logic [1:0] count_ff;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign rdata = entry_ff[rptr_ff];

   // Two-entry circular queue of classified commands.
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push && !full) wptr_ff <= !wptr_ff;
         if (pop && !empty) rptr_ff <= !rptr_ff;
         if ((push && !full) && !(pop && !empty)) count_ff <= count_ff + 2'd1;
         else if (!(push && !full) && (pop && !empty)) count_ff <= count_ff - 2'd1;
      end
      if (push && !full) entry_ff[wptr_ff] <= wdata;
   end

endmodule

// ----- design/dce_back.sv -----
module dce_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  dce_pkg::cmd_type q_data,
   output logic             q_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output dce_pkg::rsp_type rsp_data
);

   logic             active_ff;
   logic [4:0]       step_ff;
   logic             out_valid_ff;
   dce_pkg::rsp_type out_ff;

   logic             advance;
   logic [4:0]       cur_step;
   logic             at_end;
   dce_pkg::rsp_type res;

   // The output register refills in the cycle its item is taken, if a command waits in the queue.
   assign advance  = !q_empty && (!out_valid_ff || rsp_pop);
   assign cur_step = active_ff ? step_ff : dce_pkg::first_step(q_data.kind);
   assign at_end   = q_data.bad || (cur_step == dce_pkg::final_step(q_data.kind));
   assign q_pop    = advance && at_end;

   // Result for the current position; a rejected command is one empty result.
   always_comb begin
      if (q_data.bad) begin
         res = '0;
      end else begin
         res.spi_byte  = dce_pkg::seq_byte(cur_step, q_data);
         res.has_byte  = 1'b1;
         res.frame_end = dce_pkg::seq_frame_end(cur_step);
         res.io_update = at_end;
         res.ok        = 1'b1;
      end
      res.last = at_end;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            out_valid_ff <= 1'b1;
            active_ff    <= !at_end;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         out_ff  <= res;
         step_ff <= cur_step + 5'd1;
      end
   end

endmodule

// ----- design/dds_command_encoder.sv -----
// Each item passes the front part's states PH1 to PH3, the 32-step frequency divider (accepted
// single-tone or frequency commands only), the push state, the command queue and the back part's
// output register. Throughput: one result per cycle while the receiver keeps popping; a command
// yields 1 to 20 results, and the front part takes a new request only once it has pushed the
// last one into the command queue.
// Reset (synchronous, active high) empties the command queue and the output register and
// restores the clock and maximum-frequency registers to 500000000 and 200000000.
module dds_command_encoder #(
   parameter int CHANNELS = 4,
   parameter int AMP_MAX  = 1023
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  dce_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output dce_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [31:0]      csr_wdata
);

   logic             q_push;
   logic             q_full;
   logic             q_pop;
   logic             q_empty;
   dce_pkg::cmd_type q_wdata;
   dce_pkg::cmd_type q_rdata;

   // Front part: classification and word computation.
   dce_front #(
      .CHANNELS(CHANNELS),
      .AMP_MAX (AMP_MAX)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .q_push   (q_push),
      .q_full   (q_full),
      .q_data   (q_wdata)
   );

   // Command queue between the two parts.
   dce_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push (q_push),
      .full (q_full),
      .wdata(q_wdata),
      .pop  (q_pop),
      .empty(q_empty),
      .rdata(q_rdata)
   );

   // Back part: byte sequencer.
   dce_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_rdata),
      .q_pop    (q_pop),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

endmodule

// ----- sim/tb_dds_command_encoder.sv -----
module tb_dds_command_encoder;

   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_WAIT  = 50;
   localparam int LONG_HOLD   = 300;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   dce_pkg::req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   dce_pkg::rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic    csr_index = dce_pkg::CSR_SYSCLK_HZ;
   logic [31:0] csr_wdata = '0;

   // Shadow copy of the configuration registers.
   logic [31:0] clk_hz = dce_pkg::SYSCLK_RESET;
   logic [31:0] max_hz = dce_pkg::MAX_OUT_RESET;

   dce_pkg::rsp_type expected_bytes[$];
   int      errors = 0;
   int      idle_cycles = 0;
   bit      quiet = 1'b0;      // no idling on either side
   bit      long_hold = 1'b0;  // receiver backs off for a long stretch
   bit      row_typed = 1'b0;  // current item carries a typed expectation
   dce_pkg::rsp_type row_rsp;

   dds_command_encoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // One serial frame: address byte, then the data bytes.
   task automatic add_frame(input logic [7:0] addr, input logic [7:0] data[4], input int len,
                            input bit strobe);
      dce_pkg::rsp_type r;
      for (int i = -1; i < len; i++) begin
         r.spi_byte  = (i < 0) ? addr : data[i];
         r.has_byte  = 1'b1;
         r.frame_end = (i == len - 1);
         r.io_update = (i == len - 1) && strobe;
         r.ok        = 1'b1;
         r.last      = 1'b0;
         expected_bytes.push_back(r);
      end
   endtask

   task automatic add_select(input logic [2:0] ch);
      logic [7:0] d[4];
      d = '{8'(dce_pkg::SELECT_BASE << ch), 8'h00, 8'h00, 8'h00};
      add_frame(dce_pkg::ADDR_SELECT, d, 1, 1'b0);
   endtask

   task automatic add_phase(input logic [2:0] ch, input logic [15:0] deg, input bit strobe);
      logic [31:0] w;
      logic [7:0]  d[4];
      w = ((32'(deg) % 360) * 16384) / 360;
      d = '{w[15:8], w[7:0], 8'h00, 8'h00};
      add_select(ch);
      add_frame(dce_pkg::ADDR_PHASE, d, 2, strobe);
   endtask

   task automatic add_amp(input logic [2:0] ch, input logic [15:0] amp, input bit strobe);
      logic [15:0] a;
      logic [7:0]  d[4];
      a = (amp > 16'd1023) ? 16'd1023 : amp;
      d = '{8'h00, dce_pkg::AMP_ENABLE | {6'd0, a[9:8]}, a[7:0], 8'h00};
      add_select(ch);
      add_frame(dce_pkg::ADDR_AMP, d, 3, strobe);
   endtask

   task automatic add_freq(input logic [2:0] ch, input logic [31:0] f);
      logic [63:0] num;
      logic [31:0] w;
      logic [7:0]  d[4];
      num = {f, 32'd0};
      w = 32'(num / {32'd0, clk_hz});
      d = '{w[31:24], w[23:16], w[15:8], w[7:0]};
      add_select(ch);
      add_frame(dce_pkg::ADDR_FREQ, d, 4, 1'b1);
   endtask

   // Byte stream that one command produces under the current settings.
   task automatic encode_command(input dce_pkg::req_type c);
      dce_pkg::rsp_type r;
      bit      bad;
      bad = (c.channel >= 3'd4);
      if ((c.kind == dce_pkg::KIND_TONE || c.kind == dce_pkg::KIND_FREQ) &&
          (clk_hz == 0 || c.frequency_hz > max_hz || c.frequency_hz >= clk_hz / 2))
         bad = 1'b1;
      if (bad) begin
         r = '0;
         r.last = 1'b1;
         expected_bytes.push_back(r);
      end else begin
         case (c.kind)
            dce_pkg::KIND_TONE: begin
               add_select(c.channel);
               add_phase(c.channel, c.phase_deg, 1'b0);
               add_amp(c.channel, c.amplitude, 1'b0);
               add_freq(c.channel, c.frequency_hz);
            end
            dce_pkg::KIND_FREQ:  add_freq(c.channel, c.frequency_hz);
            dce_pkg::KIND_PHASE: add_phase(c.channel, c.phase_deg, 1'b1);
            default:             add_amp(c.channel, c.amplitude, 1'b1);
         endcase
         r = expected_bytes.pop_back();
         r.last = 1'b1;
         expected_bytes.push_back(r);
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] e, input logic [7:0] a);
      if (e !== a) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
         errors++;
      end
   endtask

   // Accepted items are predicted and accepted bytes checked, both at the rising edge.
   always @(posedge clock) begin
      dce_pkg::rsp_type e;
      if (!reset) begin
         if (req_push && !req_full) begin
            if (row_typed)
               expected_bytes.push_back(row_rsp);
            else
               encode_command(req_data);
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected byte, expected none, actual %0h", $time, rsp_data);
               errors++;
            end else begin
               e = expected_bytes.pop_front();
               check_field("spi_byte", e.spi_byte, rsp_data.spi_byte);
               check_field("has_byte", 8'(e.has_byte), 8'(rsp_data.has_byte));
               check_field("frame_end", 8'(e.frame_end), 8'(rsp_data.frame_end));
               check_field("io_update", 8'(e.io_update), 8'(rsp_data.io_update));
               check_field("ok", 8'(e.ok), 8'(rsp_data.ok));
               check_field("last", 8'(e.last), 8'(rsp_data.last));
            end
         end
      end
   end

   // Watchdog on cycles with no handshake on either side.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         idle_cycles <= 0;
      else if (idle_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // Receiver: random back-off bursts, one long hold, steady at the end.
   initial begin
      int gap;
      bit held;
      gap = 0;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold && !held) begin
            held = 1'b1;
            rsp_pop = 1'b0;
            for (int i = 0; i < LONG_HOLD; i++)
               @(negedge clock);
         end
         if (quiet)
            rsp_pop = 1'b1;
         else if (gap > 0) begin
            rsp_pop = 1'b0;
            gap--;
         end else if ($urandom_range(0, 7) == 0) begin
            rsp_pop = 1'b0;
            gap = $urandom_range(0, 9);
         end else
            rsp_pop = 1'b1;
      end
   end

   // Offers one item from a falling edge and returns at the falling edge after it is taken.
   task automatic send_item(input dce_pkg::req_type c);
      req_data = c;
      req_push = 1'b1;
      do
         @(posedge clock);
      while (req_full);
      @(negedge clock);
   endtask

   task automatic sender_gap();
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_push = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_push = 1'b0;
      while (expected_bytes.size() != 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [31:0] value);
      csr_we = 1'b1;
      csr_index = index;
      csr_wdata = value;
      if (index == dce_pkg::CSR_SYSCLK_HZ) begin
         if (value != 0)
            clk_hz = value;
      end else
         max_hz = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic dce_pkg::req_type random_command();
      dce_pkg::req_type c;
      logic [31:0] top;
      c.kind = 2'($urandom_range(0, 3));
      c.channel = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7)) :
                                                3'($urandom_range(0, 3));
      top = (max_hz < clk_hz / 2) ? max_hz : clk_hz / 2;
      case ($urandom_range(0, 5))
         0:       c.frequency_hz = $urandom;
         1:       c.frequency_hz = top;
         default: c.frequency_hz = $urandom_range(0, top);
      endcase
      c.phase_deg = 16'($urandom);
      c.amplitude = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 1023)) : 16'($urandom);
      return c;
   endfunction

   // Directed commands; a set reject flag gives the typed-in result.
   typedef struct {
      logic [1:0]  kind;
      logic [2:0]  channel;
      logic [31:0] freq;
      logic [15:0] deg;
      logic [15:0] amp;
      bit          reject;
   } row_type;

   row_type rows[] = '{
      '{dce_pkg::KIND_TONE,  3'd0, 32'd0,         16'd0,    16'd0,    1'b0},
      '{dce_pkg::KIND_TONE,  3'd3, 32'd200000000, 16'hFFFF, 16'hFFFF, 1'b0},
      '{dce_pkg::KIND_TONE,  3'd5, 32'd1000,      16'd90,   16'd500,  1'b1},
      '{dce_pkg::KIND_TONE,  3'd1, 32'hFFFFFFFF,  16'd10,   16'd10,   1'b1},
      '{dce_pkg::KIND_FREQ,  3'd2, 32'd123456789, 16'd0,    16'd0,    1'b0},
      '{dce_pkg::KIND_FREQ,  3'd3, 32'd0,         16'd0,    16'd0,    1'b0},
      '{dce_pkg::KIND_FREQ,  3'd0, 32'd200000001, 16'd0,    16'd0,    1'b1},
      '{dce_pkg::KIND_FREQ,  3'd4, 32'd1000,      16'd0,    16'd0,    1'b1},
      '{dce_pkg::KIND_PHASE, 3'd3, 32'hFFFFFFFF,  16'd359,  16'd0,    1'b0},
      '{dce_pkg::KIND_PHASE, 3'd0, 32'd0,         16'd360,  16'd0,    1'b0},
      '{dce_pkg::KIND_PHASE, 3'd1, 32'd0,         16'hFFFF, 16'd0,    1'b0},
      '{dce_pkg::KIND_PHASE, 3'd4, 32'd0,         16'd45,   16'd0,    1'b1},
      '{dce_pkg::KIND_AMP,   3'd2, 32'hFFFFFFFF,  16'd0,    16'd1023, 1'b0},
      '{dce_pkg::KIND_AMP,   3'd3, 32'd0,         16'd0,    16'd1024, 1'b0},
      '{dce_pkg::KIND_AMP,   3'd0, 32'd0,         16'd0,    16'd0,    1'b0},
      '{dce_pkg::KIND_AMP,   3'd7, 32'd0,         16'd0,    16'hFFFF, 1'b1}
   };

   // Settings per random phase: clock and maximum frequency.
   logic [31:0] phase_clk[4] = '{32'hFFFFFFFF, 32'd1000, 32'd0, 32'd1};
   logic [31:0] phase_max[4] = '{32'hFFFFFFFF, 32'd400, 32'd0, 32'd300000000};

   initial begin
      dce_pkg::req_type c;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) begin
         c.kind = rows[i].kind;
         c.channel = rows[i].channel;
         c.frequency_hz = rows[i].freq;
         c.phase_deg = rows[i].deg;
         c.amplitude = rows[i].amp;
         row_typed = rows[i].reject;
         row_rsp = '0;
         row_rsp.last = 1'b1;
         send_item(c);
         row_typed = 1'b0;
         sender_gap();
      end

      for (int p = 0; p < 4; p++) begin
         drain();
         write_reg(dce_pkg::CSR_SYSCLK_HZ, phase_clk[p]);
         write_reg(dce_pkg::CSR_MAX_OUTPUT_HZ, phase_max[p]);
         if (p == 1)
            long_hold = 1'b1;
         if (p == 3)
            quiet = 1'b1;
         for (int i = 0; i < 42; i++) begin
            send_item(random_command());
            sender_gap();
         end
      end

      drain();
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
